/* rtl/core/assert_macros.svh */
// assertion macros for the rtl modules, included by nfcfc_parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked at every clock edge outside reset
`define NFCFC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nfcfc assertion failed");
// checked at every clock edge, reset included
`define NFCFC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("nfcfc assertion failed");
`else
`define NFCFC_ASSERT(name, clk, rst_n, prop)
`define NFCFC_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

/* rtl/core/nfcfc_pkg.sv */
// types and constants of the nfc response frame checker
package nfcfc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 9;

  localparam logic [ByteW-1:0] DirFromDevice = 8'hD5;
  localparam logic [ByteW-1:0] StartHi       = 8'hFF;
  localparam logic [ByteW-1:0] StartLo       = 8'h00;
  localparam logic [ByteW-1:0] PostambleVal  = 8'h00;

  // byte positions inside a frame, preamble is position 0
  localparam logic [PosW-1:0] PosStartLo   = 9'd1;
  localparam logic [PosW-1:0] PosStartHi   = 9'd2;
  localparam logic [PosW-1:0] PosLen       = 9'd3;
  localparam logic [PosW-1:0] PosLcs       = 9'd4;
  localparam logic [PosW-1:0] PosDir       = 9'd5;
  localparam logic [PosW-1:0] PosCode      = 9'd6;
  localparam logic [PosW-1:0] PosFirstData = 9'd7;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StInvalid   = 2'd1,
    StBadSum    = 2'd2,
    StBadPost   = 2'd3
  } status_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindStatus  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             start;
  } in_word_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    status_e          status;
    logic             last;
  } result_t;

endpackage

/* rtl/core/nfc_response_frame_checker.sv */
// Checks reply frames from an NFC controller one byte word at a time: preamble, 00 FF, length,
// length checksum, D5, response code, payload, data checksum, postamble. frame_start in tuser
// marks the preamble. Header faults (start code, length checksum, direction, response code not
// equal to the configured command plus one) end the frame with an invalid-response status.
// Payload bytes leave as words with tuser 0; the final status word has tuser 1 and tlast 1.
// Throughput is one byte word per clock while m_axis_tready holds: a word passes an input register,
// combinational checks against the frame state, and a result register; a stall on the master side
// holds both registers.
// Write expected_command only while the block is idle.
module nfc_response_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [9:8] frame_status, rest zero
  output logic        m_axis_tuser,   // [0] item_kind
  output logic        m_axis_tlast    // frame_last
);

  nfcfc_pkg::in_word_t s_word, in_word;
  nfcfc_pkg::result_t  res, out_res;
  logic                in_valid;
  logic                can_load;
  logic                step;
  logic                res_valid;

  assign s_word.data  = s_axis_tdata;
  assign s_word.start = s_axis_tuser;
  assign step         = in_valid && can_load;

  nfcfc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .word_i    (s_word),
    .advance_i (can_load),
    .valid_o   (in_valid),
    .word_o    (in_word)
  );

  nfcfc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .word_i      (in_word),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  nfcfc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .m_ready_i   (m_axis_tready),
    .can_load_o  (can_load),
    .m_valid_o   (m_axis_tvalid),
    .res_o       (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.status, out_res.data};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

/* rtl/core/nfcfc_in_stage.sv */
// input register of the frame checker
module nfcfc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  nfcfc_pkg::in_word_t word_i,
  input  logic               advance_i,
  output logic               valid_o,
  output nfcfc_pkg::in_word_t word_o
);

  logic                valid_q, valid_d;
  nfcfc_pkg::in_word_t word_q;

  assign s_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* rtl/core/nfcfc_parser.sv */
// frame state and per-word checks of the frame checker
`include "assert_macros.svh"

module nfcfc_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 step_i,
  input  nfcfc_pkg::in_word_t  word_i,
  output logic                 res_valid_o,
  output nfcfc_pkg::result_t   res_o
);

  logic [7:0]                 cmd_q;
  logic [nfcfc_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]                 len_q, len_d;
  logic [7:0]                 sum_q, sum_d;
  logic                       hdr_ok_q, hdr_ok_d;
  logic                       done_q, done_d;
  nfcfc_pkg::status_e         cks_q, cks_d;

  logic [7:0]                 b;
  logic [7:0]                 sum_add;
  logic [7:0]                 code_exp;
  logic [7:0]                 count;
  logic [nfcfc_pkg::PosW-1:0] lim;
  logic                       code_ok;

  assign b        = word_i.data;
  assign sum_add  = sum_q + b;
  assign code_exp = cmd_q + 8'd1;
  assign count    = (len_q >= 8'd2) ? (len_q - 8'd2) : 8'd0;
  assign lim      = nfcfc_pkg::PosFirstData + {1'b0, count};
  assign code_ok  = hdr_ok_q && (b == code_exp);

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    sum_d       = sum_q;
    hdr_ok_d    = hdr_ok_q;
    done_d      = done_q;
    cks_d       = cks_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: nfcfc_pkg::KindPayload, data: 8'd0,
                    status: nfcfc_pkg::StOk, last: 1'b0};
    if (step_i) begin
      if (word_i.start) begin
        // a start mid-frame drops the open frame without a status
        pos_d    = nfcfc_pkg::PosStartLo;
        len_d    = 8'd0;
        sum_d    = 8'd0;
        hdr_ok_d = 1'b1;
        done_d   = 1'b0;
        cks_d    = nfcfc_pkg::StOk;
      end else if (!done_q) begin
        pos_d = pos_q + 9'd1;
        case (pos_q)
          nfcfc_pkg::PosStartLo: begin
            hdr_ok_d = hdr_ok_q && (b == nfcfc_pkg::StartLo);
          end
          nfcfc_pkg::PosStartHi: begin
            hdr_ok_d = hdr_ok_q && (b == nfcfc_pkg::StartHi);
          end
          nfcfc_pkg::PosLen: begin
            len_d = b;
          end
          nfcfc_pkg::PosLcs: begin
            hdr_ok_d = hdr_ok_q && ((len_q + b) == 8'd0);
          end
          nfcfc_pkg::PosDir: begin
            hdr_ok_d = hdr_ok_q && (b == nfcfc_pkg::DirFromDevice);
            sum_d    = b;
          end
          nfcfc_pkg::PosCode: begin
            hdr_ok_d = code_ok;
            sum_d    = sum_add;
            if (!code_ok) begin
              done_d       = 1'b1;
              res_valid_o  = 1'b1;
              res_o.kind   = nfcfc_pkg::KindStatus;
              res_o.status = nfcfc_pkg::StInvalid;
              res_o.last   = 1'b1;
            end
          end
          default: begin
            if (pos_q < lim) begin
              sum_d       = sum_add;
              res_valid_o = 1'b1;
              res_o.data  = b;
            end else if (pos_q == lim) begin
              // data checksum byte
              sum_d = sum_add;
              cks_d = (sum_add != 8'd0) ? nfcfc_pkg::StBadSum : nfcfc_pkg::StOk;
            end else begin
              // postamble ends the frame
              pos_d        = pos_q;
              done_d       = 1'b1;
              res_valid_o  = 1'b1;
              res_o.kind   = nfcfc_pkg::KindStatus;
              res_o.last   = 1'b1;
              res_o.status = cks_q;
              if (cks_q == nfcfc_pkg::StOk && b != nfcfc_pkg::PostambleVal) begin
                res_o.status = nfcfc_pkg::StBadPost;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q    <= 8'd0;
      pos_q    <= '0;
      len_q    <= 8'd0;
      sum_q    <= 8'd0;
      hdr_ok_q <= 1'b1;
      done_q   <= 1'b1;
      cks_q    <= nfcfc_pkg::StOk;
    end else begin
      if (cfg_we_i) begin
        cmd_q <= cfg_wdata_i;
      end
      pos_q    <= pos_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      hdr_ok_q <= hdr_ok_d;
      done_q   <= done_d;
      cks_q    <= cks_d;
    end
  end

  `NFCFC_ASSERT(a_status_closes_frame, clk_i, rst_ni,
    res_valid_o && res_o.last |=> done_q)
  `NFCFC_ASSERT(a_closed_frame_silent, clk_i, rst_ni,
    done_q && !word_i.start |-> !res_valid_o)
  `NFCFC_ASSERT(a_start_opens_frame, clk_i, rst_ni,
    step_i && word_i.start |=> !done_q && pos_q == nfcfc_pkg::PosStartLo)
  `NFCFC_ASSERT(a_payload_needs_header, clk_i, rst_ni,
    res_valid_o && res_o.kind == nfcfc_pkg::KindPayload |-> hdr_ok_q && !res_o.last)

endmodule

/* rtl/core/nfcfc_out_stage.sv */
// result register of the frame checker
module nfcfc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               res_valid_i,
  input  nfcfc_pkg::result_t res_i,
  input  logic               m_ready_i,
  output logic               can_load_o,
  output logic               m_valid_o,
  output nfcfc_pkg::result_t res_o
);

  logic               valid_q, valid_d;
  nfcfc_pkg::result_t res_q;

  assign can_load_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

/* tb/tb_nfc_response_frame_checker.sv */
// self-checking testbench for the nfc response frame checker
module tb_nfc_response_frame_checker;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_e;

  typedef enum int {
    FaultNone,
    FaultStartLo,
    FaultStartHi,
    FaultLcs,
    FaultDir,
    FaultCode,
    FaultDcs,
    FaultPost,
    FaultDcsPost
  } fault_e;

  localparam int StuckLimit = 1000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_axis_tuser  = 1'b0;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] payload_byte, [9:8] frame_status
  logic        m_axis_tuser;           // [0] item_kind
  logic        m_axis_tlast;           // frame_last

  // deframer model state
  logic [7:0]          cmd_q      = 8'h00;
  logic [8:0]          pos_q      = '0;
  logic [7:0]          len_q      = '0;
  logic [7:0]          sum_q      = '0;
  logic                hdr_ok_q   = 1'b1;
  logic                done_q     = 1'b1;
  nfcfc_pkg::status_e  csum_st_q  = nfcfc_pkg::StOk;

  nfcfc_pkg::result_t  due_words[$];
  logic [7:0]          frame_buf[$];
  idle_e               idle_mode = IdleNone;

  int fail_cnt        = 0;
  int frames_sent     = 0;
  int words_sent      = 0;
  int words_in_frames = 0;
  int results_seen    = 0;
  int status_seen[4]  = '{0, 0, 0, 0};
  int stuck_cycles    = 0;

  nfc_response_frame_checker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic void push_result(input nfcfc_pkg::kind_e kind, input logic [7:0] data,
                                      input nfcfc_pkg::status_e status, input logic last);
    nfcfc_pkg::result_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = status;
    r.last   = last;
    due_words.push_back(r);
  endfunction

  // advance the frame model by one accepted byte word
  function automatic void deframe_byte(input logic [7:0] b, input logic start);
    logic [8:0]         count;
    logic [7:0]         code_want;
    nfcfc_pkg::status_e st;
    if (start) begin
      len_q     = '0;
      sum_q     = '0;
      hdr_ok_q  = 1'b1;
      done_q    = 1'b0;
      csum_st_q = nfcfc_pkg::StOk;
      pos_q     = nfcfc_pkg::PosStartLo;
      words_in_frames++;
      return;
    end
    if (done_q) return;
    words_in_frames++;
    count     = (len_q >= 8'd2) ? {1'b0, len_q} - 9'd2 : 9'd0;
    code_want = cmd_q + 8'd1;
    case (pos_q)
      nfcfc_pkg::PosStartLo: begin
        hdr_ok_q = hdr_ok_q && (b == nfcfc_pkg::StartLo);
        pos_q    = pos_q + 9'd1;
      end
      nfcfc_pkg::PosStartHi: begin
        hdr_ok_q = hdr_ok_q && (b == nfcfc_pkg::StartHi);
        pos_q    = pos_q + 9'd1;
      end
      nfcfc_pkg::PosLen: begin
        len_q = b;
        pos_q = pos_q + 9'd1;
      end
      nfcfc_pkg::PosLcs: begin
        hdr_ok_q = hdr_ok_q && ((len_q + b) == 8'h00);
        pos_q    = pos_q + 9'd1;
      end
      nfcfc_pkg::PosDir: begin
        hdr_ok_q = hdr_ok_q && (b == nfcfc_pkg::DirFromDevice);
        sum_q    = b;
        pos_q    = pos_q + 9'd1;
      end
      nfcfc_pkg::PosCode: begin
        hdr_ok_q = hdr_ok_q && (b == code_want);
        sum_q    = sum_q + b;
        pos_q    = pos_q + 9'd1;
        if (!hdr_ok_q) begin
          done_q = 1'b1;
          push_result(nfcfc_pkg::KindStatus, 8'h00, nfcfc_pkg::StInvalid, 1'b1);
        end
      end
      default: begin
        if (pos_q < nfcfc_pkg::PosFirstData + count) begin
          sum_q = sum_q + b;
          pos_q = pos_q + 9'd1;
          push_result(nfcfc_pkg::KindPayload, b, nfcfc_pkg::StOk, 1'b0);
        end else if (pos_q == nfcfc_pkg::PosFirstData + count) begin
          sum_q     = sum_q + b;
          csum_st_q = (sum_q != 8'h00) ? nfcfc_pkg::StBadSum : nfcfc_pkg::StOk;
          pos_q     = pos_q + 9'd1;
        end else begin
          // a checksum fault hides a postamble fault
          st = csum_st_q;
          if (st == nfcfc_pkg::StOk && b != nfcfc_pkg::PostambleVal) st = nfcfc_pkg::StBadPost;
          done_q = 1'b1;
          push_result(nfcfc_pkg::KindStatus, 8'h00, st, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_cnt++;
  endtask

  // one byte word on the slave side, with a random gap in front of it in the sender-idle modes
  task automatic send_word(input logic [7:0] b, input logic start);
    int gap_pct;
    gap_pct = (idle_mode == IdleSender) ? 58 : (idle_mode == IdleBoth) ? 13 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    deframe_byte(b, start);
  endtask

  task automatic send_frame_buf();
    frames_sent++;
    for (int i = 0; i < frame_buf.size(); i++) send_word(frame_buf[i], i == 0);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (due_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_command(input logic [7:0] cmd);
    drain_results();
    // words that give no result may still be in the pipeline
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cmd;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cmd_q = cmd;
  endtask

  // build a frame of the given length into frame_buf, optionally broken
  task automatic build_frame(input logic [7:0] len, input fault_e fault);
    logic [7:0] code;
    logic [7:0] sum;
    int         n;
    code = cmd_q + 8'd1;
    sum  = nfcfc_pkg::DirFromDevice + code;
    n    = (len >= 8'd2) ? int'(len) - 2 : 0;
    frame_buf = {};
    frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf.push_back(nfcfc_pkg::StartLo);
    frame_buf.push_back(nfcfc_pkg::StartHi);
    frame_buf.push_back(len);
    frame_buf.push_back(8'h00 - len);
    frame_buf.push_back(nfcfc_pkg::DirFromDevice);
    frame_buf.push_back(code);
    for (int i = 0; i < n; i++) begin
      frame_buf.push_back(8'($urandom_range(0, 255)));
      sum = sum + frame_buf[7 + i];
    end
    frame_buf.push_back(8'h00 - sum);
    frame_buf.push_back(nfcfc_pkg::PostambleVal);
    case (fault)
      FaultStartLo: frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(1, 255));
      FaultStartHi: frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
      FaultLcs:     frame_buf[4] = frame_buf[4] ^ 8'($urandom_range(1, 255));
      FaultDir:     frame_buf[5] = frame_buf[5] ^ 8'($urandom_range(1, 255));
      FaultCode:    frame_buf[6] = frame_buf[6] ^ 8'($urandom_range(1, 255));
      FaultDcs:     frame_buf[7 + n] = frame_buf[7 + n] ^ 8'($urandom_range(1, 255));
      FaultPost:    frame_buf[8 + n] = 8'($urandom_range(1, 255));
      FaultDcsPost: begin
        frame_buf[7 + n] = frame_buf[7 + n] ^ 8'($urandom_range(1, 255));
        frame_buf[8 + n] = 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
  endtask

  task automatic send_random_frame();
    int         r;
    int         keep;
    logic [7:0] len;
    fault_e     fault;
    len = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 8)) : 8'($urandom_range(9, 40));
    r   = $urandom_range(0, 99);
    if (r < 55)      fault = FaultNone;
    else if (r < 75) fault = fault_e'($urandom_range(FaultStartLo, FaultCode));
    else if (r < 95) fault = fault_e'($urandom_range(FaultDcs, FaultDcsPost));
    else             fault = FaultNone;
    build_frame(len, fault);
    if (r >= 95) begin
      // cut short, the next frame start abandons it
      keep = $urandom_range(1, frame_buf.size() - 1);
      while (frame_buf.size() > keep) void'(frame_buf.pop_back());
    end
    send_frame_buf();
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  task automatic test_directed_cases();
    set_command(8'h00);
    idle_mode = IdleNone;
    // byte with no open frame is dropped
    send_word(8'hFF, 1'b0);
    // good frame, preamble not checked, payload 00 and ff
    frame_buf = {8'hFF, nfcfc_pkg::StartLo, nfcfc_pkg::StartHi, 8'h04, 8'hFC,
                 nfcfc_pkg::DirFromDevice, 8'h01, 8'h00, 8'hFF, 8'h2B,
                 nfcfc_pkg::PostambleVal};
    send_frame_buf();
    // frame cut off by a new frame start
    frame_buf = {8'h00, nfcfc_pkg::StartLo, nfcfc_pkg::StartHi, 8'h03};
    send_frame_buf();
    // bad data checksum and bad postamble together, checksum wins
    frame_buf = {8'h55, nfcfc_pkg::StartLo, nfcfc_pkg::StartHi, 8'h00, 8'h00,
                 nfcfc_pkg::DirFromDevice, 8'h01, 8'h00, 8'hFF};
    send_frame_buf();
  endtask

  task automatic test_stream(input idle_e mode, input logic [7:0] cmd, input int target);
    int first;
    set_command(cmd);
    idle_mode = mode;
    first = words_in_frames;
    while (words_in_frames - first < target) begin
      if ($urandom_range(0, 99) < 8) send_noise();
      else send_random_frame();
      if ($urandom_range(0, 99) < 4) drain_results();
    end
  endtask

  task automatic test_drain_pause();
    idle_mode = IdleReceiver;
    send_random_frame();
    drain_results();
    send_random_frame();
  endtask

  task automatic test_longest_frame();
    set_command(8'($urandom_range(0, 255)));
    idle_mode = IdleBoth;
    build_frame(8'hFF, FaultNone);
    send_frame_buf();
  endtask

  always @(posedge clk_i) begin
    if (idle_mode == IdleReceiver)  m_axis_tready <= ($urandom_range(0, 99) >= 58);
    else if (idle_mode == IdleBoth) m_axis_tready <= ($urandom_range(0, 99) >= 13);
    else                            m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    nfcfc_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word tdata %h tuser %b tlast %b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = due_words.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch($sformatf("kind got %b want %b", m_axis_tuser, want.kind));
        if (m_axis_tdata[7:0] !== want.data)
          report_mismatch($sformatf("payload got %h want %h", m_axis_tdata[7:0], want.data));
        if (m_axis_tdata[9:8] !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", m_axis_tdata[9:8],
                                    want.status));
        if (m_axis_tdata[15:10] !== 6'd0)
          report_mismatch($sformatf("pad bits got %h", m_axis_tdata[15:10]));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last got %b want %b", m_axis_tlast, want.last));
        if (want.kind == nfcfc_pkg::KindStatus) status_seen[want.status]++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == StuckLimit) begin
      $display("watchdog: nothing moved for %0d cycles, %0d words still due",
               StuckLimit, due_words.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_stream(IdleNone, 8'hFF, 50);
    test_stream(IdleSender, 8'h00, 50);
    test_drain_pause();
    test_stream(IdleReceiver, 8'($urandom_range(1, 254)), 50);
    test_stream(IdleBoth, 8'h7F, 50);
    test_longest_frame();
    drain_results();
    repeat (10) @(posedge clk_i);
    $display("sent %0d frames in %0d byte words, checked %0d result words",
             frames_sent, words_sent, results_seen);
    $display("status words ok %0d, invalid %0d, bad checksum %0d, bad postamble %0d",
             status_seen[nfcfc_pkg::StOk], status_seen[nfcfc_pkg::StInvalid],
             status_seen[nfcfc_pkg::StBadSum], status_seen[nfcfc_pkg::StBadPost]);
    if (fail_cnt == 0) $display("ALL CHECKS PASSED");
    else               $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/nfcfc_pkg.sv
rtl/core/nfcfc_in_stage.sv
rtl/core/nfcfc_parser.sv
rtl/core/nfcfc_out_stage.sv
rtl/core/nfc_response_frame_checker.sv
tb/tb_nfc_response_frame_checker.sv
